FILE: rtl/nppw_pkg.sv
// Package for the nearest waypoint lookahead window block.
// Holds shared types, constants and the controller state type; no dependencies.
package nppw_pkg;

    localparam int unsigned MAX_POINTS_DEF = 1024;
    localparam int unsigned MIN_SPAN       = 4;
    localparam int unsigned MIN_POINTS     = 5;
    localparam int unsigned CFG_W          = 31;
    localparam int unsigned IDX_W          = 10;
    localparam int unsigned DSQ_W          = 65;
    localparam int unsigned ROOT_W         = 34;
    localparam logic [30:0] WIN_RESET      = 31'd3840;

    // Configuration register indexes.
    localparam logic REG_TRACK_POINTS = 1'b0;
    localparam logic REG_MAX_WINDOW   = 1'b1;

    // Input operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_SQ,
        ST_SCAN_CMP,
        ST_WALK_RD,
        ST_WALK_SQ,
        ST_ROOT,
        ST_ACC,
        ST_FINISH,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_query; // capture position and reset scan
        logic mem_rd;     // read the table at the current pointer
        logic sq_calc;    // register squares of differences
        logic scan_cmp;   // compare against best, advance pointer
        logic walk_init;  // set walk pointer to best and clear length
        logic root_init;  // start square root
        logic root_step;  // one bit of the square root
        logic acc;        // add root to length
        logic finish;     // form window
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic walk_done;
        logic root_last;
        logic few;
    } t_sts;

endpackage

FILE: rtl/nppw_ctrl.sv
// Controller state machine for the nearest waypoint lookahead window block.
// Depends on nppw_pkg for the state, command and status types.
module nppw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_op,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  nppw_pkg::t_sts  i_sts,
    output nppw_pkg::t_cmd  o_cmd
);

    nppw_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nppw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nppw_pkg::ST_IDLE: begin
                if (i_valid && i_op == nppw_pkg::OP_QUERY) begin
                    n_state = nppw_pkg::ST_SCAN_RD;
                end
            end
            nppw_pkg::ST_SCAN_RD: begin
                n_state = i_sts.few ? nppw_pkg::ST_FINISH : nppw_pkg::ST_SCAN_SQ;
            end
            nppw_pkg::ST_SCAN_SQ:  n_state = nppw_pkg::ST_SCAN_CMP;
            nppw_pkg::ST_SCAN_CMP: begin
                n_state = i_sts.scan_last ? nppw_pkg::ST_WALK_RD : nppw_pkg::ST_SCAN_RD;
            end
            nppw_pkg::ST_WALK_RD: begin
                n_state = i_sts.walk_done ? nppw_pkg::ST_FINISH : nppw_pkg::ST_WALK_SQ;
            end
            nppw_pkg::ST_WALK_SQ: n_state = nppw_pkg::ST_ROOT;
            nppw_pkg::ST_ROOT: begin
                if (i_sts.root_last) begin
                    n_state = nppw_pkg::ST_ACC;
                end
            end
            nppw_pkg::ST_ACC:    n_state = nppw_pkg::ST_WALK_RD;
            nppw_pkg::ST_FINISH: n_state = nppw_pkg::ST_OUT;
            nppw_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_state = nppw_pkg::ST_IDLE;
                end
            end
            default: n_state = nppw_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            nppw_pkg::ST_IDLE: begin
                o_ready          = 1'b1;
                o_cmd.load_query = i_valid && i_op == nppw_pkg::OP_QUERY;
            end
            nppw_pkg::ST_SCAN_RD:  o_cmd.mem_rd = 1'b1;
            nppw_pkg::ST_SCAN_SQ:  o_cmd.sq_calc = 1'b1;
            nppw_pkg::ST_SCAN_CMP: begin
                o_cmd.scan_cmp  = 1'b1;
                o_cmd.walk_init = i_sts.scan_last;
            end
            nppw_pkg::ST_WALK_RD:  o_cmd.mem_rd = 1'b1;
            nppw_pkg::ST_WALK_SQ: begin
                o_cmd.sq_calc   = 1'b1;
                o_cmd.root_init = 1'b1;
            end
            nppw_pkg::ST_ROOT:   o_cmd.root_step = 1'b1;
            nppw_pkg::ST_ACC:    o_cmd.acc = 1'b1;
            nppw_pkg::ST_FINISH: o_cmd.finish = 1'b1;
            nppw_pkg::ST_OUT:    o_valid = 1'b1;
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    // A result is only offered after the window is formed.
    a_out_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == nppw_pkg::ST_FINISH)
        else $error("result offered without finish");
    // Input is never taken while a result waits.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready while result pending");
    // The square root step only runs in its own state.
    a_root_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.root_step |-> r_state == nppw_pkg::ST_ROOT)
        else $error("root step outside root state");
`endif

endmodule

FILE: rtl/nppw_dp.sv
// Datapath of the nearest waypoint lookahead window block: table, scan, walk, root.
// Depends on nppw_pkg for constants and the command and status types.
module nppw_dp #(
    parameter int unsigned MAX_POINTS = nppw_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [nppw_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_load,
    input  logic [nppw_pkg::IDX_W-1:0]    i_point_index,
    input  logic signed [31:0]            i_pos_x,
    input  logic signed [31:0]            i_pos_y,
    input  nppw_pkg::t_cmd                i_cmd,
    output nppw_pkg::t_sts                o_sts,
    output logic [nppw_pkg::IDX_W-1:0]    o_start_index,
    output logic [nppw_pkg::IDX_W-1:0]    o_end_index,
    output logic                          o_status
);

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned NW = AW + 1;
    localparam int unsigned RW = nppw_pkg::ROOT_W;
    localparam int unsigned DW = nppw_pkg::DSQ_W;
    localparam int unsigned LW = 48;

    logic [31:0] r_mem_x [MAX_POINTS];
    logic [31:0] r_mem_y [MAX_POINTS];

    logic [10:0]               r_track;
    logic [nppw_pkg::CFG_W-1:0] r_maxlen;
    logic signed [31:0]        r_qx, r_qy;
    logic signed [31:0]        r_rx, r_ry;
    logic signed [31:0]        r_prev_x, r_prev_y;
    logic signed [31:0]        r_best_x, r_best_y;
    logic [63:0]               r_sx, r_sy;
    logic [DW-1:0]             r_best_d;
    logic                      r_first;
    logic [AW-1:0]             r_ptr;
    logic [AW-1:0]             r_best;
    logic [AW:0]               r_front;
    logic [LW-1:0]             r_len;
    logic [RW-1:0]             r_root;
    logic [$clog2(RW)-1:0]     r_bit;
    logic [nppw_pkg::IDX_W-1:0] r_start, r_end;
    logic                      r_status;
    logic                      r_walk;

    logic [NW-1:0]  w_n;
    logic [AW-1:0]  w_rd_addr;
    logic [DW-1:0]  w_dsum;
    logic [RW-1:0]  w_cand;
    logic [67:0]    w_csq;
    logic [AW:0]    w_end;
    logic           w_better;

    // Effective point count, limited to the table depth.
    assign w_n = (32'(r_track) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(r_track);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track  <= '0;
            r_maxlen <= nppw_pkg::WIN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == nppw_pkg::REG_TRACK_POINTS) begin
                r_track <= i_cfg_data[10:0];
            end else begin
                r_maxlen <= i_cfg_data;
            end
        end
    end

    // Waypoint table: one write port, one registered read. The walk reads the
    // point after the current front.
    assign w_rd_addr = r_walk ? (r_front[AW-1:0] + AW'(1)) : r_ptr;
    always_ff @(posedge i_clk) begin
        if (i_load && 32'(i_point_index) < MAX_POINTS) begin
            r_mem_x[AW'(i_point_index)] <= i_pos_x;
            r_mem_y[AW'(i_point_index)] <= i_pos_y;
        end
        if (i_cmd.mem_rd) begin
            r_rx <= r_mem_x[w_rd_addr];
            r_ry <= r_mem_y[w_rd_addr];
        end
    end

    // Squares of coordinate differences against the query or previous point.
    // The walk starts with the nearest point as its previous point.
    always_ff @(posedge i_clk) begin
        logic signed [32:0] v_dx, v_dy;
        logic [31:0]        v_ax, v_ay;
        if (i_cmd.sq_calc) begin
            v_dx = r_walk ? (33'(r_rx) - 33'(r_prev_x)) : (33'(r_qx) - 33'(r_rx));
            v_dy = r_walk ? (33'(r_ry) - 33'(r_prev_y)) : (33'(r_qy) - 33'(r_ry));
            v_ax = v_dx[32] ? 32'(-v_dx) : 32'(v_dx);
            v_ay = v_dy[32] ? 32'(-v_dy) : 32'(v_dy);
            r_sx <= 64'(v_ax) * 64'(v_ax);
            r_sy <= 64'(v_ay) * 64'(v_ay);
            r_prev_x <= r_rx;
            r_prev_y <= r_ry;
        end else if (i_cmd.walk_init) begin
            r_prev_x <= w_better ? r_rx : r_best_x;
            r_prev_y <= w_better ? r_ry : r_best_y;
        end
    end
    // A difference is below 2^32 in size, so each square fits 64 bits and the sum 65.
    assign w_dsum = {1'b0, r_sx} + {1'b0, r_sy};

    // The point just compared beats the best so far; the first one always does.
    assign w_better = r_first || (w_dsum < r_best_d);

    // Square root, one bit a cycle, from the top bit down.
    assign w_cand = r_root | (RW'(1) << r_bit);
    assign w_csq  = 68'(w_cand) * 68'(w_cand);

    // Scan, walk and root control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk  <= 1'b0;
            r_first <= 1'b0;
            r_ptr   <= '0;
        end else begin
            if (i_cmd.load_query) begin
                r_qx    <= i_pos_x;
                r_qy    <= i_pos_y;
                r_ptr   <= '0;
                r_first <= 1'b1;
                r_walk  <= 1'b0;
            end
            if (i_cmd.scan_cmp) begin
                if (w_better) begin
                    r_best_d <= w_dsum;
                    r_best   <= r_ptr;
                    r_best_x <= r_rx;
                    r_best_y <= r_ry;
                end
                r_first <= 1'b0;
                r_ptr   <= r_ptr + AW'(1);
            end
            if (i_cmd.walk_init) begin
                r_walk  <= 1'b1;
                r_front <= w_better ? {1'b0, r_ptr} : {1'b0, r_best};
                r_len   <= '0;
            end
            if (i_cmd.mem_rd && r_walk && !o_sts.walk_done) begin
                r_front <= r_front + (AW+1)'(1);
            end
            if (i_cmd.root_init) begin
                r_root <= '0;
                r_bit  <= $clog2(RW)'(RW - 1);
            end
            if (i_cmd.root_step) begin
                if (w_csq <= 68'(w_dsum)) begin
                    r_root <= w_cand;
                end
                r_bit <= r_bit - $clog2(RW)'(1);
            end
            if (i_cmd.acc) begin
                r_len <= r_len + LW'(r_root);
            end
            if (i_cmd.finish) begin
                r_walk <= 1'b0;
            end
        end
    end

    // Window end, widened to the minimum span past the nearest point.
    assign w_end = (r_front - {1'b0, r_best} < (AW+1)'(nppw_pkg::MIN_SPAN))
                   ? {1'b0, r_best} + (AW+1)'(nppw_pkg::MIN_SPAN) : r_front;

    // Window result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (w_n < NW'(nppw_pkg::MIN_POINTS)) begin
                r_start  <= '0;
                r_end    <= '0;
                r_status <= 1'b1;
            end else if ((NW+1)'(w_end) >= (NW+1)'(w_n)) begin
                r_start  <= '0;
                r_end    <= nppw_pkg::IDX_W'(nppw_pkg::MIN_SPAN);
                r_status <= 1'b0;
            end else begin
                r_start  <= nppw_pkg::IDX_W'(r_best);
                r_end    <= nppw_pkg::IDX_W'(w_end);
                r_status <= 1'b0;
            end
        end
    end

    // Status to the controller.
    assign o_sts.few       = w_n < NW'(nppw_pkg::MIN_POINTS);
    assign o_sts.scan_last = (NW'(r_ptr) + NW'(1)) >= w_n;
    assign o_sts.walk_done = r_len >= LW'(r_maxlen) || (NW'(r_front) + NW'(1)) >= w_n;
    assign o_sts.root_last = r_bit == '0;

    assign o_start_index = r_start;
    assign o_end_index   = r_end;
    assign o_status      = r_status;

`ifndef NO_ASSERTIONS
    // The walk never runs past the last valid point.
    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_walk && !o_sts.few) |-> NW'(r_front) < w_n)
        else $error("walk past table end");
    // A short table always reports the error status.
    a_few_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && o_sts.few) |=> r_status)
        else $error("short table not flagged");
    // The root candidate is never above the true root.
    a_root_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc |-> 68'(r_root) * 68'(r_root) <= 68'(w_dsum))
        else $error("root too large");
`endif

endmodule

FILE: rtl/nearest_point_path_window.sv
// Nearest waypoint lookahead window. A load beat writes one waypoint. A
// query beat scans all N loaded points, each through read, square and
// compare states, then walks forward; each segment goes through read,
// square, the one-bit-a-cycle square root and accumulate states. When
// fewer than five points are loaded, the result is formed without a scan
// or walk. One query is worked on at a time; no beat is taken until its
// result has been accepted.
module nearest_point_path_window #(
    parameter int unsigned MAX_POINTS = nppw_pkg::MAX_POINTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [nppw_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [nppw_pkg::IDX_W-1:0]  i_point_index,
    input  logic signed [31:0]          i_pos_x,
    input  logic signed [31:0]          i_pos_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [nppw_pkg::IDX_W-1:0]  o_start_index,
    output logic [nppw_pkg::IDX_W-1:0]  o_end_index,
    output logic                        o_status
);

    nppw_pkg::t_cmd w_cmd;
    nppw_pkg::t_sts w_sts;

    // Controller.
    nppw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Datapath.
    nppw_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_load        (i_valid && o_ready && i_op == nppw_pkg::OP_LOAD),
        .i_point_index (i_point_index),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_start_index (o_start_index),
        .o_end_index   (o_end_index),
        .o_status      (o_status)
    );

endmodule
